// ===== rtl/lbft_pkg.sv =====
// ----------------------------------------------------------------------------
// lbft_pkg: shared codes and types
// Operation codes, result status codes and the controller command bundle of
// the LRU buffer frame table.
// ----------------------------------------------------------------------------
`default_nettype none

package lbft_pkg;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_EVICT  = 2'd2;
    localparam logic [1:0] OP_SETPIN = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_DUP  = 2'd3;

    typedef struct packed {
        logic start;
        logic scan_rd;
        logic sweep_rd;
        logic decide;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic sweep;
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/lbft_ctrl.sv =====
// ----------------------------------------------------------------------------
// lbft_ctrl: operation sequencer
// Steps each beat through a scan of all entries, a decision, an optional
// recency sweep and a commit that loads the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lbft_ctrl
    import lbft_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         out_ready,
    output logic                              out_valid,
    input  wire sts_t                         sts,
    output cmd_t                              cmd,
    output logic [$clog2(ENTRIES)-1:0]        addr
);

    localparam int IW = $clog2(ENTRIES);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_SCAN      = 3'd1;
    localparam logic [2:0] S_SCAN_END  = 3'd2;
    localparam logic [2:0] S_DECIDE    = 3'd3;
    localparam logic [2:0] S_SWEEP     = 3'd4;
    localparam logic [2:0] S_SWEEP_END = 3'd5;
    localparam logic [2:0] S_COMMIT    = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [IW-1:0] count_reg, count_next;
    logic          out_valid_reg, out_valid_next;
    logic          last;

    assign last      = (count_reg == IW'(ENTRIES - 1));
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign addr      = count_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    count_next = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (last)
                    state_next = S_SCAN_END;
                else
                    count_next = count_reg + IW'(1);
            end
            S_SCAN_END:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                count_next = '0;
                state_next = sts.sweep ? S_SWEEP : S_COMMIT;
            end
            S_SWEEP:
            begin
                cmd.sweep_rd = 1'b1;
                if (last)
                    state_next = S_SWEEP_END;
                else
                    count_next = count_reg + IW'(1);
            end
            S_SWEEP_END:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lbft_dp.sv =====
// ----------------------------------------------------------------------------
// lbft_dp: entry store, free frame stack and result register
// Holds the entries in a single-port-write memory, evaluates one entry a
// cycle during scan and sweep, and applies the operation on commit.
// ----------------------------------------------------------------------------
`default_nettype none

module lbft_dp
    import lbft_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire cmd_t                         cmd,
    input  wire logic [$clog2(ENTRIES)-1:0]   addr,
    output sts_t                              sts,
    input  wire logic [4:0]                   cache_size,
    input  wire logic [1:0]                   op,
    input  wire logic [7:0]                   table_id,
    input  wire logic [23:0]                  page_index,
    input  wire logic                         pinned,
    output logic [1:0]                        status,
    output logic [3:0]                        frame,
    output logic [7:0]                        evicted_table,
    output logic [23:0]                       evicted_page,
    output logic [4:0]                        fill_count,
    output logic                              full_res
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int WW = (CW > 5) ? CW : 5;

    typedef struct packed {
        logic [7:0]    tab;
        logic [23:0]   page;
        logic          pin;
        logic [IW-1:0] frm;
        logic [IW-1:0] rank;
    } entry_t;

    entry_t        entry_mem [ENTRIES];
    entry_t        rd_reg;
    logic [IW-1:0] free_mem [ENTRIES];
    logic [IW-1:0] free_rd_reg;

    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] free_wr_reg;
    logic [CW-1:0]      free_top_reg;
    logic [CW-1:0]      used_reg;
    logic               eval_scan_reg;
    logic               eval_sweep_reg;
    logic [IW-1:0]      eval_addr_reg;

    logic [1:0]    op_reg;
    logic [7:0]    tid_reg;
    logic [23:0]   pg_reg;
    logic          pin_reg;
    logic          hit_found_reg, slot_found_reg, vic_found_reg;
    logic [IW-1:0] hit_idx_reg, slot_idx_reg, vic_idx_reg;
    entry_t        hit_reg, vic_reg;
    logic          ok_reg;
    logic [1:0]    st_reg;
    logic [IW-1:0] ref_rank_reg;

    logic [1:0]    status_reg;
    logic [3:0]    frame_reg;
    logic [7:0]    etab_reg;
    logic [23:0]   epg_reg;
    logic [4:0]    fill_reg;
    logic          full_reg;

    logic [WW-1:0] cap;
    logic          full_now;
    logic [1:0]    st_now;
    logic [IW-1:0] top_m1;
    logic [IW-1:0] pop_frame;
    entry_t        sweep_word;
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    entry_t        mem_wd;
    logic          do_insert, do_evict, do_setpin;
    logic [CW-1:0] used_after;
    logic [3:0]    frame_res;

    assign cap = (WW'(cache_size) < WW'(ENTRIES)) ? WW'(cache_size) : WW'(ENTRIES);
    assign full_now = (WW'(used_reg) >= cap) || (free_top_reg == '0);
    assign top_m1 = IW'(free_top_reg - CW'(1));
    assign pop_frame = free_wr_reg[top_m1] ? free_rd_reg : top_m1;

    always_comb
    begin
        case (op_reg)
            OP_LOOKUP: st_now = hit_found_reg ? ST_OK : ST_MISS;
            OP_INSERT:
            begin
                if (hit_found_reg)
                    st_now = ST_DUP;
                else if (full_now || !slot_found_reg)
                    st_now = ST_FULL;
                else
                    st_now = ST_OK;
            end
            OP_EVICT:  st_now = vic_found_reg ? ST_OK : ST_MISS;
            default:   st_now = hit_found_reg ? ST_OK : ST_MISS;
        endcase
    end

    assign sts.sweep = (st_now == ST_OK) && (op_reg != OP_SETPIN);

    always_comb
    begin
        sweep_word = rd_reg;
        case (op_reg)
            OP_LOOKUP:
            begin
                if (eval_addr_reg == hit_idx_reg)
                    sweep_word.rank = '0;
                else if (rd_reg.rank < ref_rank_reg)
                    sweep_word.rank = rd_reg.rank + IW'(1);
            end
            OP_INSERT:
            begin
                sweep_word.rank = rd_reg.rank + IW'(1);
            end
            OP_EVICT:
            begin
                if (rd_reg.rank > ref_rank_reg)
                    sweep_word.rank = rd_reg.rank - IW'(1);
            end
            default:
            begin
                sweep_word = rd_reg;
            end
        endcase
    end

    assign do_insert = cmd.commit && ok_reg && (op_reg == OP_INSERT);
    assign do_evict  = cmd.commit && ok_reg && (op_reg == OP_EVICT);
    assign do_setpin = cmd.commit && ok_reg && (op_reg == OP_SETPIN);

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = eval_addr_reg;
        mem_wd = sweep_word;
        if (eval_sweep_reg && valid_reg[eval_addr_reg])
            mem_we = 1'b1;
        else if (do_insert)
        begin
            mem_we = 1'b1;
            mem_wa = slot_idx_reg;
            mem_wd = '{tab: tid_reg, page: pg_reg, pin: pin_reg, frm: pop_frame, rank: '0};
        end
        else if (do_setpin)
        begin
            mem_we     = 1'b1;
            mem_wa     = hit_idx_reg;
            mem_wd     = hit_reg;
            mem_wd.pin = pin_reg;
        end
    end

    always_comb
    begin
        used_after = used_reg;
        if (do_insert)
            used_after = used_reg + CW'(1);
        else if (do_evict && used_reg != '0)
            used_after = used_reg - CW'(1);
    end

    always_comb
    begin
        frame_res = '0;
        if (ok_reg)
        begin
            case (op_reg)
                OP_INSERT: frame_res = 4'(pop_frame);
                OP_EVICT:  frame_res = 4'(vic_reg.frm);
                default:   frame_res = 4'(hit_reg.frm);
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            entry_mem[mem_wa] <= mem_wd;
        rd_reg <= entry_mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (do_evict && free_top_reg < CW'(ENTRIES))
            free_mem[free_top_reg[IW-1:0]] <= vic_reg.frm;
        free_rd_reg <= free_mem[top_m1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            free_wr_reg    <= '0;
            free_top_reg   <= CW'(ENTRIES);
            used_reg       <= '0;
            eval_scan_reg  <= 1'b0;
            eval_sweep_reg <= 1'b0;
        end
        else
        begin
            eval_scan_reg  <= cmd.scan_rd;
            eval_sweep_reg <= cmd.sweep_rd;
            if (do_evict)
                valid_reg[vic_idx_reg] <= 1'b0;
            if (do_insert)
            begin
                valid_reg[slot_idx_reg] <= 1'b1;
                free_top_reg <= free_top_reg - CW'(1);
            end
            if (do_evict && free_top_reg < CW'(ENTRIES))
            begin
                free_wr_reg[free_top_reg[IW-1:0]] <= 1'b1;
                free_top_reg <= free_top_reg + CW'(1);
            end
            used_reg <= used_after;
        end
    end

    always_ff @(posedge clk)
    begin
        eval_addr_reg <= addr;
        if (cmd.start)
        begin
            op_reg         <= op;
            tid_reg        <= table_id;
            pg_reg         <= page_index;
            pin_reg        <= pinned;
            hit_found_reg  <= 1'b0;
            slot_found_reg <= 1'b0;
            vic_found_reg  <= 1'b0;
        end
        if (eval_scan_reg)
        begin
            if (valid_reg[eval_addr_reg] && !hit_found_reg && rd_reg.tab == tid_reg
                && rd_reg.page == pg_reg)
            begin
                hit_found_reg <= 1'b1;
                hit_idx_reg   <= eval_addr_reg;
                hit_reg       <= rd_reg;
            end
            if (!valid_reg[eval_addr_reg] && !slot_found_reg)
            begin
                slot_found_reg <= 1'b1;
                slot_idx_reg   <= eval_addr_reg;
            end
            if (valid_reg[eval_addr_reg] && !rd_reg.pin
                && (!vic_found_reg || rd_reg.rank > vic_reg.rank))
            begin
                vic_found_reg <= 1'b1;
                vic_idx_reg   <= eval_addr_reg;
                vic_reg       <= rd_reg;
            end
        end
        if (cmd.decide)
        begin
            ok_reg       <= (st_now == ST_OK);
            st_reg       <= st_now;
            ref_rank_reg <= (op_reg == OP_EVICT) ? vic_reg.rank : hit_reg.rank;
        end
        if (cmd.commit)
        begin
            status_reg <= st_reg;
            frame_reg  <= frame_res;
            etab_reg   <= (ok_reg && op_reg == OP_EVICT) ? vic_reg.tab : '0;
            epg_reg    <= (ok_reg && op_reg == OP_EVICT) ? vic_reg.page : '0;
            fill_reg   <= 5'(used_after);
            full_reg   <= (WW'(used_after) >= cap);
        end
    end

    assign status        = status_reg;
    assign frame         = frame_reg;
    assign evicted_table = etab_reg;
    assign evicted_page  = epg_reg;
    assign fill_count    = fill_reg;
    assign full_res      = full_reg;

    a_frames_conserved: assert property (@(posedge clk) disable iff (!rst_n)
        (CW+1)'(free_top_reg) + (CW+1)'(used_reg) == (CW+1)'(ENTRIES))
        else $error("free frames and used entries do not add up");

    a_fill_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(used_reg))
        else $error("fill count disagrees with valid entries");

    a_insert_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        do_insert |=> valid_reg[$past(slot_idx_reg)])
        else $error("inserted slot not marked valid");

endmodule

`default_nettype wire

// ===== rtl/lru_buffer_frame_table.sv =====
// ----------------------------------------------------------------------------
// lru_buffer_frame_table: LRU buffer frame table with pinned entries
// Each beat runs from acceptance to result through one pass over the entry
// memory to find the key, a free slot and the least recent unpinned entry, a
// decision step, a second pass that rewrites recency ranks (skipped for set-pin
// and failed beats), and a commit step. The entry memory has one read and one
// write port, which sets one entry per cycle. A new beat is taken as soon as
// the previous one has been committed to the result register, even while that
// result waits. No clearing pass follows reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_buffer_frame_table
    import lbft_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [4:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  op,
    input  wire logic [7:0]  table_id,
    input  wire logic [23:0] page_index,
    input  wire logic        pinned,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [3:0]       frame,
    output logic [7:0]       evicted_table,
    output logic [23:0]      evicted_page,
    output logic [4:0]       fill_count,
    output logic             full_res
);

    cmd_t                       cmd;
    sts_t                       sts;
    logic [$clog2(ENTRIES)-1:0] addr;
    logic [4:0]                 cache_size_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cache_size_reg <= 5'd16;
        else if (cfg_valid && cfg_ready)
            cache_size_reg <= cfg_data;
    end

    lbft_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .sts       (sts),
        .cmd       (cmd),
        .addr      (addr)
    );

    lbft_dp #(.ENTRIES(ENTRIES)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .addr          (addr),
        .sts           (sts),
        .cache_size    (cache_size_reg),
        .op            (op),
        .table_id      (table_id),
        .page_index    (page_index),
        .pinned        (pinned),
        .status        (status),
        .frame         (frame),
        .evicted_table (evicted_table),
        .evicted_page  (evicted_page),
        .fill_count    (fill_count),
        .full_res      (full_res)
    );

endmodule

`default_nettype wire

// ===== test/frame_table_checker.sv =====
// ----------------------------------------------------------------------------
// frame_table_checker: result predictor and scoreboard
// Watches the register, request and result channels of the LRU buffer frame
// table. It keeps its own copy of the entries, recency ranks and free frame
// stack, and works out the result of each accepted request. Each result beat
// is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module frame_table_checker
    import lbft_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [4:0]  cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  op,
    input  logic [7:0]  table_id,
    input  logic [23:0] page_index,
    input  logic        pinned,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  status,
    input  logic [3:0]  frame,
    input  logic [7:0]  evicted_table,
    input  logic [23:0] evicted_page,
    input  logic [4:0]  fill_count,
    input  logic        full_res,
    output int          fail_count,
    output int          outstanding
);

    localparam int SLOTS = 16;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  frame;
        logic [7:0]  evicted_table;
        logic [23:0] evicted_page;
        logic [4:0]  fill_count;
        logic        full_res;
    } table_result_t;

    table_result_t pending_results[$];

    logic        slot_valid  [SLOTS];
    logic [7:0]  slot_table  [SLOTS];
    logic [23:0] slot_page   [SLOTS];
    logic        slot_pinned [SLOTS];
    logic [3:0]  slot_frame  [SLOTS];
    logic [3:0]  slot_rank   [SLOTS];
    logic [3:0]  free_stack  [SLOTS];
    int          stack_top;
    int          used_entries;
    logic [4:0]  cache_size;

    assign outstanding = pending_results.size();

    function automatic int capacity();
        return (cache_size < SLOTS) ? int'(cache_size) : SLOTS;
    endfunction

    function automatic int find_slot(logic [7:0] tid, logic [23:0] pg);
        for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i] && slot_table[i] == tid && slot_page[i] == pg)
                return i;
        return -1;
    endfunction

    task automatic apply_request(input logic [1:0] code, input logic [7:0] tid,
                                 input logic [23:0] pg, input logic pin);
        table_result_t res;
        int            hit;
        int            victim;
        logic [3:0]    r;
        res = '0;
        res.status = ST_OK;
        case (code)
            OP_LOOKUP, OP_SETPIN:
            begin
                hit = find_slot(tid, pg);
                if (hit < 0)
                    res.status = ST_MISS;
                else
                begin
                    if (code == OP_LOOKUP)
                    begin
                        r = slot_rank[hit];
                        for (int i = 0; i < SLOTS; i++)
                            if (slot_valid[i] && slot_rank[i] < r)
                                slot_rank[i]++;
                        slot_rank[hit] = 0;
                    end
                    else
                        slot_pinned[hit] = pin;
                    res.frame = slot_frame[hit];
                end
            end
            OP_INSERT:
            begin
                if (find_slot(tid, pg) >= 0)
                    res.status = ST_DUP;
                else if (used_entries >= capacity() || stack_top == 0)
                    res.status = ST_FULL;
                else
                begin
                    hit = -1;
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (!slot_valid[i])
                            hit = i;
                    for (int i = 0; i < SLOTS; i++)
                        if (slot_valid[i])
                            slot_rank[i]++;
                    stack_top--;
                    slot_frame[hit]  = free_stack[stack_top];
                    slot_valid[hit]  = 1'b1;
                    slot_table[hit]  = tid;
                    slot_page[hit]   = pg;
                    slot_pinned[hit] = pin;
                    slot_rank[hit]   = 0;
                    used_entries++;
                    res.frame = slot_frame[hit];
                end
            end
            default:
            begin
                victim = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (slot_valid[i] && !slot_pinned[i] &&
                        (victim < 0 || slot_rank[i] > slot_rank[victim]))
                        victim = i;
                if (victim < 0)
                    res.status = ST_MISS;
                else
                begin
                    r = slot_rank[victim];
                    slot_valid[victim] = 1'b0;
                    for (int i = 0; i < SLOTS; i++)
                        if (slot_valid[i] && slot_rank[i] > r)
                            slot_rank[i]--;
                    if (stack_top < SLOTS)
                    begin
                        free_stack[stack_top] = slot_frame[victim];
                        stack_top++;
                    end
                    if (used_entries > 0)
                        used_entries--;
                    res.frame         = slot_frame[victim];
                    res.evicted_table = slot_table[victim];
                    res.evicted_page  = slot_page[victim];
                end
            end
        endcase
        res.fill_count = 5'(used_entries);
        res.full_res   = (used_entries >= capacity());
        pending_results = {pending_results, res};
    endtask

    task automatic compare_result();
        table_result_t want;
        if (pending_results.size() == 0)
        begin
            $error("result beat with no prediction waiting");
            fail_count++;
            return;
        end
        want = pending_results.pop_front();
        if (status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, status);
            fail_count++;
        end
        if (frame !== want.frame)
        begin
            $error("frame: expected %0d, got %0d", want.frame, frame);
            fail_count++;
        end
        if (evicted_table !== want.evicted_table)
        begin
            $error("evicted_table: expected %0h, got %0h", want.evicted_table,
                   evicted_table);
            fail_count++;
        end
        if (evicted_page !== want.evicted_page)
        begin
            $error("evicted_page: expected %0h, got %0h", want.evicted_page,
                   evicted_page);
            fail_count++;
        end
        if (fill_count !== want.fill_count)
        begin
            $error("fill_count: expected %0d, got %0d", want.fill_count, fill_count);
            fail_count++;
        end
        if (full_res !== want.full_res)
        begin
            $error("full_res: expected %0d, got %0d", want.full_res, full_res);
            fail_count++;
        end
    endtask

    initial fail_count = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_valid[i]  = 1'b0;
                slot_table[i]  = '0;
                slot_page[i]   = '0;
                slot_pinned[i] = 1'b0;
                slot_frame[i]  = '0;
                slot_rank[i]   = '0;
                free_stack[i]  = 4'(i);
            end
            stack_top    = SLOTS;
            used_entries = 0;
            cache_size   = 5'd16;
            pending_results.delete();
        end
        else
        begin
            if (out_valid && out_ready)
                compare_result();
            if (cfg_valid && cfg_ready)
                cache_size = cfg_data;
            if (in_valid && in_ready)
                apply_request(op, table_id, page_index, pinned);
        end
    end

endmodule

// ===== test/lru_buffer_frame_table_test.sv =====
// ----------------------------------------------------------------------------
// lru_buffer_frame_table_test: testbench top
// Drives directed and random lookup, insert, evict and set-pin requests into
// the LRU buffer frame table over several cache sizes, with random idling on
// both sides and a long result stall. The checker beside the block predicts
// and compares every result.
// ----------------------------------------------------------------------------
module lru_buffer_frame_table_test;
    import lbft_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int KEY_POOL    = 20;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [4:0]  cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  op;
    logic [7:0]  table_id;
    logic [23:0] page_index;
    logic        pinned;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [3:0]  frame;
    logic [7:0]  evicted_table;
    logic [23:0] evicted_page;
    logic [4:0]  fill_count;
    logic        full_res;
    int          fail_count;
    int          outstanding;

    int          requests_sent;
    int          cycle_count;
    logic        quiet;
    logic        hold_off;
    logic [7:0]  pool_table [KEY_POOL];
    logic [23:0] pool_page  [KEY_POOL];

    lru_buffer_frame_table DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .op(op), .table_id(table_id),
        .page_index(page_index), .pinned(pinned),
        .out_valid(out_valid), .out_ready(out_ready), .status(status),
        .frame(frame), .evicted_table(evicted_table),
        .evicted_page(evicted_page), .fill_count(fill_count), .full_res(full_res)
    );

    frame_table_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .op(op), .table_id(table_id),
        .page_index(page_index), .pinned(pinned),
        .out_valid(out_valid), .out_ready(out_ready), .status(status),
        .frame(frame), .evicted_table(evicted_table),
        .evicted_page(evicted_page), .fill_count(fill_count),
        .full_res(full_res), .fail_count(fail_count), .outstanding(outstanding)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(negedge clk)
        out_ready <= !hold_off && (quiet || $urandom_range(99) >= 17);

    // hold results back long enough for the request side to back up
    initial
    begin
        hold_off = 1'b0;
        wait (requests_sent >= 700);
        @(negedge clk);
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        @(negedge clk);
        hold_off = 1'b0;
    end

    task automatic send_request(input logic [1:0] code, input logic [7:0] tid,
                                input logic [23:0] pg, input logic pin);
        if (!quiet && $urandom_range(99) < 17)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        op         = code;
        table_id   = tid;
        page_index = pg;
        pinned     = pin;
        in_valid   = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic write_cache_size(input logic [4:0] value);
        drain();
        repeat (40) @(negedge clk);
        cfg_data  = value;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic random_requests(input int count);
        logic [1:0]  code;
        logic [7:0]  tid;
        logic [23:0] pg;
        int          pick;
        int          k;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            code = (pick < 30) ? OP_LOOKUP : (pick < 65) ? OP_INSERT :
                   (pick < 85) ? OP_EVICT : OP_SETPIN;
            if ($urandom_range(99) < 85)
            begin
                k   = $urandom_range(KEY_POOL - 1);
                tid = pool_table[k];
                pg  = pool_page[k];
            end
            else
            begin
                tid = 8'($urandom);
                pg  = 24'($urandom);
            end
            send_request(code, tid, pg, $urandom_range(99) < 25);
        end
    endtask

    initial
    begin
        logic [4:0] sizes [8];
        sizes = '{5'd16, 5'd31, 5'd8, 5'd1, 5'd0, 5'd5, 5'd12, 5'd16};
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        op            = OP_LOOKUP;
        table_id      = '0;
        page_index    = '0;
        pinned        = 1'b0;
        out_ready     = 1'b0;
        quiet         = 1'b0;
        requests_sent = 0;
        cycle_count   = 0;
        for (int i = 0; i < KEY_POOL; i++)
        begin
            pool_table[i] = 8'($urandom);
            pool_page[i]  = 24'($urandom);
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_request(OP_LOOKUP, 8'h00, 24'h000000, 1'b0);
        send_request(OP_EVICT,  8'h00, 24'h000000, 1'b0);
        send_request(OP_SETPIN, 8'hFF, 24'hFFFFFF, 1'b1);
        send_request(OP_INSERT, 8'h00, 24'h000000, 1'b0);
        send_request(OP_INSERT, 8'hFF, 24'hFFFFFF, 1'b1);
        send_request(OP_INSERT, 8'h00, 24'h000000, 1'b1);
        send_request(OP_LOOKUP, 8'hFF, 24'hFFFFFF, 1'b0);
        send_request(OP_SETPIN, 8'h00, 24'h000000, 1'b1);
        send_request(OP_EVICT,  8'h00, 24'h000000, 1'b0);
        send_request(OP_SETPIN, 8'hFF, 24'hFFFFFF, 1'b0);
        send_request(OP_EVICT,  8'h00, 24'h000000, 1'b0);
        send_request(OP_LOOKUP, 8'h00, 24'h000000, 1'b0);
        write_cache_size(5'd2);
        send_request(OP_INSERT, 8'h5A, 24'hA5A5A5, 1'b0);
        send_request(OP_INSERT, 8'hA5, 24'h5A5A5A, 1'b0);
        send_request(OP_INSERT, 8'h00, 24'h000000, 1'b0);
        write_cache_size(5'd1);
        send_request(OP_INSERT, 8'h01, 24'h000001, 1'b0);
        send_request(OP_LOOKUP, 8'h5A, 24'hA5A5A5, 1'b0);
        send_request(OP_SETPIN, 8'h00, 24'h000000, 1'b0);
        send_request(OP_EVICT,  8'h00, 24'h000000, 1'b0);
        send_request(OP_EVICT,  8'h00, 24'h000000, 1'b0);
        send_request(OP_EVICT,  8'h00, 24'h000000, 1'b0);

        for (int p = 0; p < 8; p++)
        begin
            write_cache_size(sizes[p]);
            quiet = (p == 2);
            random_requests(230);
        end
        drain();
        repeat (50) @(negedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
